>>> design/skvt_pkg.sv
// ----------------------------------------------------------------------------
// Sorted key-value table package
// Sizes, operation and status codes, and the entry and write-port types
// shared by the table sequencer and its entry memory.
// ----------------------------------------------------------------------------
package skvt_pkg;

  localparam int unsigned SLOTS    = 64;
  localparam int unsigned CAPACITY = 64;
  localparam int unsigned CAP_EFF  = (CAPACITY > SLOTS) ? SLOTS : CAPACITY;
  localparam int unsigned ADDR_W   = $clog2(SLOTS);
  localparam int unsigned CNT_W    = ADDR_W + 1;
  localparam int unsigned KEY_W    = 32;
  localparam int unsigned VAL_W    = 32;

  typedef enum logic [2:0] {
    OP_INSERT         = 3'd0,
    OP_FIND           = 3'd1,
    OP_REMOVE         = 3'd2,
    OP_ITERATE        = 3'd3,
    OP_FIND_OR_INSERT = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [VAL_W-1:0] value;
  } entry_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    entry_t            data;
  } mem_wr_t;

endpackage

>>> design/sorted_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key-value table unit
// Unique signed keys with value handles, kept in ascending key order in a
// single-port-read, single-port-write memory and served by a small sequencer.
//
//   channel   direction  handshake             payload
//   request   in         start_i, busy_o       func_i, key_i, value_i
//   result    out        strobe_o (one cycle)  status_o, out_key_o,
//                                              out_value_o, last_o
//
// A request is taken when start_i is high and busy_o is low. Find, insert,
// remove and find_or_insert scan the memory one entry a cycle from slot 0;
// remove then moves the tail down one entry a cycle, and insert moves it up
// and writes the new entry. The result strobe comes in the same cycle that
// busy_o falls. Iterate emits one result a cycle once the registered read
// of slot 0 returns. Unused codes and iterate of an empty table answer in
// the cycle after acceptance. Reset empties the table at once. Results
// cannot be held off by the receiver.
// ----------------------------------------------------------------------------
module sorted_key_value_table_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  output logic               busy_o,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0]        value_i,
  output logic               strobe_o,
  output logic [1:0]         status_o,
  output logic signed [31:0] out_key_o,
  output logic [31:0]        out_value_o,
  output logic               last_o
);
  import skvt_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_ITER,
    S_SHIFT_DN,
    S_SHIFT_UP
  } state_e;

  state_e state_q, state_d;

  logic [2:0]       op_q, op_d;
  logic [KEY_W-1:0] key_q, key_d;
  logic [VAL_W-1:0] val_q, val_d;
  logic [VAL_W-1:0] held_q, held_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] pos_q, pos_d;

  logic             strobe_q, strobe_d;
  logic [1:0]       status_q, status_d;
  logic [KEY_W-1:0] okey_q, okey_d;
  logic [VAL_W-1:0] oval_q, oval_d;
  logic             last_q, last_d;

  mem_wr_t           mem_wr;
  logic [ADDR_W-1:0] rd_addr;
  entry_t            rd_entry;

  logic [CNT_W-1:0] idx_inc, idx_dec, idx_p2, idx_m2, cnt_dec;
  logic             at_end, cur_lt, key_eq, full;

  skvt_mem u_mem (
    .clk_i   (clk_i),
    .wr_i    (mem_wr),
    .raddr_i (rd_addr),
    .rdata_o (rd_entry)
  );

  assign idx_inc = idx_q + CNT_W'(1);
  assign idx_dec = idx_q - CNT_W'(1);
  assign idx_p2  = idx_q + CNT_W'(2);
  assign idx_m2  = idx_q - CNT_W'(2);
  assign cnt_dec = count_q - CNT_W'(1);
  assign at_end  = (idx_q == count_q);
  assign full    = (count_q >= CNT_W'(CAP_EFF));
  assign key_eq  = (rd_entry.key == key_q);
  // Flipping the sign bit turns the signed order into an unsigned one.
  assign cur_lt  = {~rd_entry.key[KEY_W-1], rd_entry.key[KEY_W-2:0]}
                 < {~key_q[KEY_W-1], key_q[KEY_W-2:0]};

  always_comb begin
    state_d  = state_q;
    op_d     = op_q;
    key_d    = key_q;
    val_d    = val_q;
    held_d   = held_q;
    count_d  = count_q;
    idx_d    = idx_q;
    pos_d    = pos_q;
    strobe_d = 1'b0;
    status_d = status_q;
    okey_d   = okey_q;
    oval_d   = oval_q;
    last_d   = last_q;
    mem_wr   = '0;
    rd_addr  = '0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op_d  = func_i;
          key_d = key_i;
          val_d = value_i;
          idx_d = '0;
          unique case (func_i) inside
            OP_ITERATE: begin
              if (count_q == '0) begin
                strobe_d = 1'b1;
                status_d = ST_NOT_FOUND;
                okey_d   = '0;
                oval_d   = '0;
                last_d   = 1'b1;
              end else begin
                state_d = S_ITER;
              end
            end
            OP_INSERT, OP_FIND, OP_REMOVE, OP_FIND_OR_INSERT: begin
              state_d = S_SEARCH;
            end
            default: begin
              strobe_d = 1'b1;
              status_d = ST_NOT_FOUND;
              okey_d   = key_i;
              oval_d   = '0;
              last_d   = 1'b1;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (!at_end && cur_lt) begin
          idx_d   = idx_inc;
          rd_addr = idx_inc[ADDR_W-1:0];
        end else if (!at_end && key_eq) begin
          okey_d = key_q;
          oval_d = rd_entry.value;
          last_d = 1'b1;
          if (op_q == OP_INSERT) begin
            strobe_d = 1'b1;
            status_d = ST_PRESENT;
            state_d  = S_IDLE;
          end else if (op_q == OP_REMOVE) begin
            // Close the gap: slot idx takes the entry above it, read ahead.
            held_d  = rd_entry.value;
            rd_addr = idx_inc[ADDR_W-1:0];
            state_d = S_SHIFT_DN;
          end else begin
            strobe_d = 1'b1;
            status_d = ST_OK;
            state_d  = S_IDLE;
          end
        end else begin
          okey_d = key_q;
          oval_d = '0;
          last_d = 1'b1;
          if (op_q == OP_FIND || op_q == OP_REMOVE) begin
            strobe_d = 1'b1;
            status_d = ST_NOT_FOUND;
            state_d  = S_IDLE;
          end else if (full) begin
            strobe_d = 1'b1;
            status_d = ST_FULL;
            state_d  = S_IDLE;
          end else begin
            // Open a gap at idx by moving entries up from the top.
            pos_d   = idx_q;
            idx_d   = count_q;
            rd_addr = cnt_dec[ADDR_W-1:0];
            state_d = S_SHIFT_UP;
          end
        end
      end

      S_ITER: begin
        strobe_d = 1'b1;
        status_d = ST_OK;
        okey_d   = rd_entry.key;
        oval_d   = rd_entry.value;
        last_d   = (idx_inc == count_q);
        idx_d    = idx_inc;
        rd_addr  = idx_inc[ADDR_W-1:0];
        if (idx_inc == count_q) begin
          state_d = S_IDLE;
        end
      end

      S_SHIFT_DN: begin
        if (idx_inc >= count_q) begin
          count_d  = cnt_dec;
          strobe_d = 1'b1;
          status_d = ST_OK;
          okey_d   = key_q;
          oval_d   = held_q;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_wr.en   = 1'b1;
          mem_wr.addr = idx_q[ADDR_W-1:0];
          mem_wr.data = rd_entry;
          idx_d       = idx_inc;
          rd_addr     = idx_p2[ADDR_W-1:0];
        end
      end

      S_SHIFT_UP: begin
        mem_wr.en   = 1'b1;
        mem_wr.addr = idx_q[ADDR_W-1:0];
        if (idx_q == pos_q) begin
          mem_wr.data.key   = key_q;
          mem_wr.data.value = val_q;
          count_d  = count_q + CNT_W'(1);
          strobe_d = 1'b1;
          status_d = ST_OK;
          okey_d   = key_q;
          oval_d   = val_q;
          last_d   = 1'b1;
          state_d  = S_IDLE;
        end else begin
          mem_wr.data = rd_entry;
          idx_d       = idx_dec;
          rd_addr     = idx_m2[ADDR_W-1:0];
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      strobe_q <= 1'b0;
      status_q <= '0;
      okey_q   <= '0;
      oval_q   <= '0;
      last_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
      status_q <= status_d;
      okey_q   <= okey_d;
      oval_q   <= oval_d;
      last_q   <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    key_q    <= key_d;
    val_q    <= val_d;
    held_q   <= held_d;
    idx_q    <= idx_d;
    pos_q    <= pos_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign strobe_o    = strobe_q;
  assign status_o    = status_q;
  assign out_key_o   = $signed(okey_q);
  assign out_value_o = oval_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  // The entry count never exceeds the table capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(CAP_EFF))
    else $error("entry count above capacity");

  // An accepted request either occupies the sequencer or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> (busy_o || strobe_o))
    else $error("accepted request produced neither work nor result");

  // A result that is not the last one only appears while an iteration runs.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (strobe_o && !last_o) |-> busy_o)
    else $error("non-final result outside an iteration");

  // The table only changes size together with the result of that request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q != $past(count_q)) |-> strobe_o)
    else $error("entry count changed without a result");
`endif

endmodule

>>> design/skvt_mem.sv
// ----------------------------------------------------------------------------
// Sorted key-value table entry memory
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module skvt_mem (
  input  logic                           clk_i,
  input  skvt_pkg::mem_wr_t              wr_i,
  input  logic [skvt_pkg::ADDR_W-1:0]    raddr_i,
  output skvt_pkg::entry_t               rdata_o
);
  import skvt_pkg::*;

  entry_t mem_q [SLOTS];
  entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

>>> test/skvt_table_checker.sv
// ----------------------------------------------------------------------------
// Sorted key-value table checker
// Watches the request and result channels of the table unit, keeps its own
// sorted copy of the table, and compares every result in order against the
// answers predicted when each request transaction was accepted.
// ----------------------------------------------------------------------------
module skvt_table_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic [2:0]         func_i,
  input  logic signed [31:0] key_i,
  input  logic [31:0]        value_i,
  input  logic               strobe_i,
  input  logic [1:0]         status_i,
  input  logic signed [31:0] out_key_i,
  input  logic [31:0]        out_value_i,
  input  logic               last_i,
  output int unsigned        fail_count_o,
  output int unsigned        outstanding_o,
  output int unsigned        checked_o
);
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
  } kv_pair_t;

  typedef struct {
    status_e                 status;
    logic signed [KEY_W-1:0] key;
    logic [VAL_W-1:0]        value;
    logic                    last;
  } table_answer_t;

  kv_pair_t      sorted_pairs[$];
  table_answer_t answer_q[$];
  table_answer_t head_answer;

  function automatic void push_answer(status_e st, logic signed [KEY_W-1:0] k,
                                      logic [VAL_W-1:0] v, logic l);
    table_answer_t a;
    a.status = st;
    a.key    = k;
    a.value  = v;
    a.last   = l;
    answer_q.push_back(a);
  endfunction

  function automatic void apply_request(logic [2:0] func, logic signed [KEY_W-1:0] key,
                                        logic [VAL_W-1:0] value);
    int unsigned      pos;
    bit               hit;
    logic [VAL_W-1:0] held;
    kv_pair_t         fresh;
    pos = 0;
    if (func == OP_ITERATE) begin
      if (sorted_pairs.size() == 0) begin
        push_answer(ST_NOT_FOUND, '0, '0, 1'b1);
      end else begin
        foreach (sorted_pairs[i])
          push_answer(ST_OK, sorted_pairs[i].key, sorted_pairs[i].value,
                      i == sorted_pairs.size() - 1);
      end
    end else if (func > OP_FIND_OR_INSERT) begin
      push_answer(ST_NOT_FOUND, key, '0, 1'b1);
    end else begin
      // Both sides are signed, so this walks to the first key not below the request.
      while (pos < sorted_pairs.size() && sorted_pairs[pos].key < key) pos++;
      hit = (pos < sorted_pairs.size()) && (sorted_pairs[pos].key == key);
      if (hit) begin
        held = sorted_pairs[pos].value;
        if (func == OP_INSERT) begin
          push_answer(ST_PRESENT, key, held, 1'b1);
        end else begin
          if (func == OP_REMOVE) sorted_pairs.delete(pos);
          push_answer(ST_OK, key, held, 1'b1);
        end
      end else if (func == OP_FIND || func == OP_REMOVE) begin
        push_answer(ST_NOT_FOUND, key, '0, 1'b1);
      end else if (sorted_pairs.size() >= CAP_EFF) begin
        push_answer(ST_FULL, key, '0, 1'b1);
      end else begin
        fresh.key   = key;
        fresh.value = value;
        sorted_pairs.insert(pos, fresh);
        push_answer(ST_OK, key, value, 1'b1);
      end
    end
  endfunction

  task automatic report_mismatch(string what, logic [31:0] expected_val,
                                 logic [31:0] seen_val);
    $display("%0t: result mismatch on %s: expected %h, got %h",
             $realtime, what, expected_val, seen_val);
    fail_count_o++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sorted_pairs.delete();
      answer_q.delete();
      checked_o = 0;
      outstanding_o <= 0;
    end else begin
      if (start_i && !busy_i) apply_request(func_i, key_i, value_i);
      if (strobe_i) begin
        if (answer_q.size() == 0) begin
          report_mismatch("unexpected result, key", '0, out_key_i);
        end else begin
          head_answer = answer_q.pop_front();
          checked_o++;
          if (status_i !== head_answer.status)
            report_mismatch("status", head_answer.status, status_i);
          if (out_key_i !== head_answer.key)
            report_mismatch("key", head_answer.key, out_key_i);
          if (out_value_i !== head_answer.value)
            report_mismatch("value", head_answer.value, out_value_i);
          if (last_i !== head_answer.last)
            report_mismatch("last", head_answer.last, last_i);
        end
      end
      // Updated late so the stimulus side sees a settled count at each edge.
      outstanding_o <= answer_q.size();
    end
  end

endmodule

>>> test/tb_sorted_key_value_table_unit.sv
// ----------------------------------------------------------------------------
// Sorted key-value table unit testbench
// Drives directed and random request transactions with random idle bursts,
// fills the table past capacity and drains it again, and leaves checking to
// the table checker that sits beside the unit.
// ----------------------------------------------------------------------------
module tb_sorted_key_value_table_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import skvt_pkg::*;

  localparam int unsigned KEY_POOL_SIZE = 16;
  localparam int unsigned STALL_LIMIT   = 4000;
  localparam int unsigned SETTLE_CYCLES = 300;
  localparam logic [2:0]  UNUSED_OP_LO  = 3'd5;
  localparam logic [2:0]  UNUSED_OP_MID = 3'd6;
  localparam logic [2:0]  UNUSED_OP_HI  = 3'd7;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7fff_ffff;

  logic               clk_i   = 1'b0;
  logic               rst_ni  = 1'b0;
  logic               start_i = 1'b0;
  logic [2:0]         func_i  = OP_FIND;
  logic signed [31:0] key_i   = '0;
  logic [31:0]        value_i = '0;
  logic               busy_o;
  logic               strobe_o;
  logic [1:0]         status_o;
  logic signed [31:0] out_key_o;
  logic [31:0]        out_value_o;
  logic               last_o;

  int unsigned        fail_count;
  int unsigned        outstanding;
  int unsigned        checked;
  int unsigned        sent_count = 0;
  int unsigned        quiet_cycles = 0;
  bit                 idling_on = 1'b0;
  logic signed [31:0] key_pool[KEY_POOL_SIZE];
  logic signed [31:0] fill_keys[$];

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  sorted_key_value_table_unit i_dut (
    .clk_i, .rst_ni, .start_i, .busy_o, .func_i, .key_i, .value_i,
    .strobe_o, .status_o, .out_key_o, .out_value_o, .last_o
  );

  skvt_table_checker i_checker (
    .clk_i, .rst_ni, .start_i,
    .busy_i        (busy_o),
    .func_i, .key_i, .value_i,
    .strobe_i      (strobe_o),
    .status_i      (status_o),
    .out_key_i     (out_key_o),
    .out_value_i   (out_value_o),
    .last_i        (last_o),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .checked_o     (checked)
  );

  // Any accepted request or any result counts as progress.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start_i && !busy_o) || strobe_o) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("FAIL sorted_key_value_table_unit");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  task automatic issue(logic [2:0] f, logic signed [31:0] k, logic [31:0] v);
    if (idling_on && $urandom_range(0, 3) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk_i);
    end
    func_i  <= f;
    key_i   <= k;
    value_i <= v;
    start_i <= 1'b1;
    do @(posedge clk_i); while (busy_o);
    sent_count++;
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [2:0] pick_op();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 28) return OP_INSERT;
    if (r < 48) return OP_FIND;
    if (r < 63) return OP_REMOVE;
    if (r < 83) return OP_FIND_OR_INSERT;
    if (r < 90) return OP_ITERATE;
    return 3'($urandom_range(UNUSED_OP_LO, UNUSED_OP_HI));
  endfunction

  function automatic logic signed [31:0] pick_key();
    if ($urandom_range(0, 3) != 0) return key_pool[$urandom_range(0, KEY_POOL_SIZE - 1)];
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_value();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  task automatic random_mix(int unsigned count);
    repeat (count) issue(pick_op(), pick_key(), pick_value());
  endtask

  initial begin
    logic signed [31:0] k;
    int unsigned        j;

    key_pool[0] = KEY_MIN;
    key_pool[1] = KEY_MAX;
    key_pool[2] = '0;
    key_pool[3] = -32'sd1;
    for (int i = 4; i < KEY_POOL_SIZE; i++) key_pool[i] = $urandom;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty table, key extremes, duplicates, every operation.
    issue(OP_ITERATE, 32'sd77, '0);
    issue(OP_FIND, KEY_MIN, '0);
    issue(OP_REMOVE, KEY_MAX, '0);
    issue(OP_INSERT, KEY_MIN, '1);
    issue(OP_INSERT, KEY_MAX, '0);
    issue(OP_INSERT, '0, 32'h5555_5555);
    issue(OP_INSERT, -32'sd1, 32'haaaa_aaaa);
    issue(OP_INSERT, KEY_MIN, 32'h1234_5678);
    issue(OP_FIND, KEY_MAX, '1);
    issue(OP_FIND, 32'sd5, '0);
    issue(OP_FIND_OR_INSERT, -32'sd1, 32'hdead_beef);
    issue(OP_FIND_OR_INSERT, 32'sd1234, 32'hcafe_f00d);
    issue(UNUSED_OP_LO, 32'sh0f0f_0f0f, '1);
    issue(UNUSED_OP_MID, KEY_MIN, '1);
    issue(UNUSED_OP_HI, KEY_MAX, '0);
    issue(OP_ITERATE, '0, '0);
    issue(OP_REMOVE, -32'sd1, '0);
    issue(OP_REMOVE, -32'sd1, '0);
    issue(OP_FIND, '0, '0);
    issue(OP_ITERATE, KEY_MAX, '1);

    idling_on = 1'b1;
    random_mix(120);

    // Hold off until the table has answered everything, then fill it.
    wait_drained();
    for (int i = 0; i < CAP_EFF + 6; i++) begin
      k = $urandom;
      fill_keys.push_back(k);
      issue(($urandom_range(0, 1) != 0) ? OP_INSERT : OP_FIND_OR_INSERT, k, pick_value());
    end
    issue(OP_ITERATE, '0, '0);
    issue(OP_INSERT, fill_keys[0], pick_value());
    issue(OP_FIND_OR_INSERT, fill_keys[1], pick_value());
    issue(OP_INSERT, $urandom, pick_value());
    issue(OP_FIND_OR_INSERT, $urandom, pick_value());
    issue(OP_FIND, fill_keys[2], '0);

    // Drain in random order, with lookups mixed in.
    while (fill_keys.size() != 0) begin
      j = $urandom_range(0, fill_keys.size() - 1);
      if ($urandom_range(0, 3) == 0) begin
        issue(OP_FIND, fill_keys[j], pick_value());
      end else begin
        issue(OP_REMOVE, fill_keys[j], pick_value());
        fill_keys.delete(j);
      end
    end
    issue(OP_ITERATE, '0, '0);

    idling_on = 1'b0;
    random_mix(40);
    issue(OP_ITERATE, '0, '0);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Sent %0d requests: every operation and unused codes, key extremes,", sent_count);
    $display("empty and full table, with %0d results compared in order.", checked);
    if (fail_count == 0 && outstanding == 0) begin
      $display("PASS sorted_key_value_table_unit");
    end else begin
      if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
      $display("FAIL sorted_key_value_table_unit");
    end
    $finish;
  end

endmodule
